// ===== hw/rtl/mfw_pkg.sv =====
// Shared types, constants and the sorting-round function of the 3x3 median filter.
// Depends on nothing; every other file of the filter imports it.
package mfw_pkg;

    // Width of one pixel and the size of the padded sorting network.
    localparam int PIXEL_WIDTH = 8;
    localparam int WIN_PIXELS  = 9;
    localparam int NET_LEN     = 10;
    // One pipeline stage performs one even and one odd phase.
    localparam int NUM_STAGES  = NET_LEN / 2;
    // Position of the median in the sorted ten values.
    localparam int MEDIAN_POS  = 5;

    typedef logic [PIXEL_WIDTH-1:0] pixel_t;
    typedef pixel_t [NET_LEN-1:0]   net_vec_t;

    // One even phase on pairs (0,1)..(8,9), then one odd phase on pairs (1,2)..(7,8).
    // Each phase is a row of independent compare-exchange cells.
    function automatic net_vec_t sort_round(input net_vec_t v);
        net_vec_t e;
        net_vec_t o;
        e = v;
        for (int i = 0; i + 1 < NET_LEN; i += 2)
        begin
            if (!(v[i] < v[i+1]))
            begin
                e[i]   = v[i+1];
                e[i+1] = v[i];
            end
        end
        o = e;
        for (int i = 1; i + 1 < NET_LEN - 1; i += 2)
        begin
            if (!(e[i] < e[i+1]))
            begin
                o[i]   = e[i+1];
                o[i+1] = e[i];
            end
        end
        return o;
    endfunction

endpackage

// ===== hw/rtl/mfw_if.sv =====
// Stream interfaces of the 3x3 median filter: the window channel and the result channel.
// Depends on mfw_pkg for the pixel type.
interface mfw_win_if import mfw_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t pixel_0;
    pixel_t pixel_1;
    pixel_t pixel_2;
    pixel_t pixel_3;
    pixel_t pixel_4;
    pixel_t pixel_5;
    pixel_t pixel_6;
    pixel_t pixel_7;
    pixel_t pixel_8;

    modport source (output valid, output pixel_0, output pixel_1, output pixel_2,
                    output pixel_3, output pixel_4, output pixel_5, output pixel_6,
                    output pixel_7, output pixel_8, input ready);
    modport sink   (input valid, input pixel_0, input pixel_1, input pixel_2,
                    input pixel_3, input pixel_4, input pixel_5, input pixel_6,
                    input pixel_7, input pixel_8, output ready);
endinterface

interface mfw_med_if import mfw_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t median_value;

    modport source (output valid, output median_value, input ready);
    modport sink   (input valid, input median_value, output ready);
endinterface

// ===== hw/rtl/mfw_sort_stage.sv =====
// One register stage of the sorting pipeline: two compare-exchange phases and a register.
// Depends on mfw_pkg for the vector type and the sorting-round function.
module mfw_sort_stage
    import mfw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     up_valid,
    output logic     up_ready,
    input  net_vec_t up_data,
    output logic     dn_valid,
    input  logic     dn_ready,
    output net_vec_t dn_data
);

    logic     valid_reg;
    net_vec_t data_reg;

    // The stage takes a transfer when it is empty or its content moves on.
    assign up_ready = !valid_reg || dn_ready;

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // Payload register; it holds while the stage is stalled.
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= sort_round(up_data);
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== hw/rtl/median_of_3x3_window_core.sv =====
// 3x3 median filter: a five-stage pipeline of an odd-even transposition sorting network.
// Depends on mfw_pkg, mfw_if and mfw_sort_stage.
//
// Each transfer on the window channel carries nine pixels; the filter returns their
// median, the fifth smallest, on the result channel. A new window is taken in every
// cycle while the result channel takes results, and each result is registered: the ten
// padded values pass five register stages, each of which performs one even and one odd
// compare-exchange phase. While the result channel stalls, empty stages still take
// windows until the pipeline is full; no window is lost or repeated. There is no
// configuration and no state beyond the pipeline, and reset only empties it.
module median_of_3x3_window_core
    import mfw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mfw_win_if.sink   win,
    mfw_med_if.source med
);

    logic     stage_valid [NUM_STAGES+1];
    logic     stage_ready [NUM_STAGES+1];
    net_vec_t stage_data  [NUM_STAGES+1];

    // Pad the window with the least pixel value to ten entries.
    always_comb
    begin
        stage_data[0]    = '0;
        stage_data[0][0] = win.pixel_0;
        stage_data[0][1] = win.pixel_1;
        stage_data[0][2] = win.pixel_2;
        stage_data[0][3] = win.pixel_3;
        stage_data[0][4] = win.pixel_4;
        stage_data[0][5] = win.pixel_5;
        stage_data[0][6] = win.pixel_6;
        stage_data[0][7] = win.pixel_7;
        stage_data[0][8] = win.pixel_8;
    end

    assign stage_valid[0] = win.valid;
    assign win.ready      = stage_ready[0];

    // Chain of sorting stages.
    for (genvar s = 0; s < NUM_STAGES; s++)
    begin : g_stage
        mfw_sort_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[s]),
            .up_ready (stage_ready[s]),
            .up_data  (stage_data[s]),
            .dn_valid (stage_valid[s+1]),
            .dn_ready (stage_ready[s+1]),
            .dn_data  (stage_data[s+1])
        );
    end

    // The last stage register is the output register.
    assign med.valid                = stage_valid[NUM_STAGES];
    assign med.median_value         = stage_data[NUM_STAGES][MEDIAN_POS];
    assign stage_ready[NUM_STAGES]  = med.ready;

endmodule

// ===== hw/rtl/mfw_checker.sv =====
// Port-level checks of the 3x3 median filter, bound to the top level.
// Depends on mfw_pkg and on the top level's interface ports.
module mfw_checker
    import mfw_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input pixel_t out_median
);

    logic [2:0] count_reg;
    logic [2:0] count_next;

    // Number of windows taken whose results have not yet been delivered.
    always_comb
    begin
        count_next = count_reg;
        if (in_valid && in_ready)
        begin
            count_next = count_next + 3'd1;
        end
        if (out_valid && out_ready && (count_next != 3'd0))
        begin
            count_next = count_next - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // A stalled result stays and keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_median))
        else $error("stalled result changed or vanished");

    // With an empty output register the whole pipeline can take a window.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("window refused while the output register is empty");

    // No more windows in flight than there are stages.
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(NUM_STAGES))
        else $error("more windows in flight than pipeline stages");

    // A result is shown only for a window that was taken.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_reg != 3'd0)
        else $error("result shown with no window in flight");

endmodule

bind median_of_3x3_window_core mfw_checker u_mfw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (win.valid),
    .in_ready   (win.ready),
    .out_valid  (med.valid),
    .out_ready  (med.ready),
    .out_median (med.median_value)
);

// ===== dv/tb_median_of_3x3_window_core.sv =====
// Self-checking testbench for the 3x3 median filter core.
// Depends on mfw_pkg, the mfw_win_if and mfw_med_if interfaces and the core itself.
// Windows go in through a valid/ready source and medians are checked against a local sorting network.
`timescale 1ns / 100ps

module tb_median_of_3x3_window_core;
    import mfw_pkg::*;

    localparam int          CLK_PERIOD    = 8;
    localparam int          RESET_CYCLES  = 12;
    localparam int          IDLE_PERCENT  = 37;
    localparam int unsigned HOLD_CYCLES   = 160;
    localparam int unsigned DRAIN_CYCLES  = 12;
    localparam int unsigned CYCLE_LIMIT   = 250000;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int          NUM_DIRECTED  = 13;

    // Kinds of random window content.
    typedef enum int
    {
        STYLE_UNIFORM,
        STYLE_NARROW_BAND,
        STYLE_SALT_PEPPER,
        STYLE_IMPULSE
    } window_style_t;

    typedef pixel_t window_t [WIN_PIXELS];

    logic clk = 1'b0;
    logic rst_n;

    mfw_win_if win_ch ();
    mfw_med_if med_ch ();

    pixel_t      expected_medians [$];
    int unsigned windows_accepted   = 0;
    int unsigned medians_checked    = 0;
    int unsigned input_stall_cycles = 0;
    int unsigned failure_count      = 0;
    int unsigned cycle_count        = 0;
    bit          no_idling          = 1'b0;
    bit          hold_request       = 1'b0;

    median_of_3x3_window_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .win   (win_ch),
        .med   (med_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Median of nine pixels: pad with zero and run ten alternating transposition phases.
    function automatic pixel_t predict_median(input window_t px);
        pixel_t lane [NET_LEN];
        pixel_t swap;
        for (int i = 0; i < WIN_PIXELS; i++)
            lane[i] = px[i];
        lane[NET_LEN-1] = '0;
        for (int phase = 0; phase < NET_LEN; phase++)
        begin
            for (int i = phase % 2; i + 1 < NET_LEN; i += 2)
            begin
                if (!(lane[i] < lane[i+1]))
                begin
                    swap      = lane[i];
                    lane[i]   = lane[i+1];
                    lane[i+1] = swap;
                end
            end
        end
        return lane[MEDIAN_POS];
    endfunction

    // Failures are counted always, but only the first few are described.
    function automatic void note_failure(input string what);
        failure_count++;
        if (failure_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Record every accepted window and check every accepted median against the oldest prediction.
    always @(posedge clk)
    begin : scoreboard
        window_t seen;
        pixel_t  wanted;
        if (rst_n === 1'b1)
        begin
            if (win_ch.valid === 1'b1 && win_ch.ready === 1'b1)
            begin
                seen = '{win_ch.pixel_0, win_ch.pixel_1, win_ch.pixel_2,
                         win_ch.pixel_3, win_ch.pixel_4, win_ch.pixel_5,
                         win_ch.pixel_6, win_ch.pixel_7, win_ch.pixel_8};
                expected_medians.push_back(predict_median(seen));
                windows_accepted++;
            end
            else if (win_ch.valid === 1'b1)
                input_stall_cycles++;

            if (med_ch.valid === 1'b1 && med_ch.ready === 1'b1)
            begin
                if (expected_medians.size() == 0)
                    note_failure($sformatf("median %0d arrived with no window outstanding",
                                           med_ch.median_value));
                else
                begin
                    wanted = expected_medians.pop_front();
                    if (med_ch.median_value !== wanted)
                        note_failure($sformatf("median_value expected %0d, got %0d",
                                               wanted, med_ch.median_value));
                    medians_checked++;
                end
            end
        end
    end

    // Result receiver: random stalls, a steady mode, and one long hold-off on request.
    initial
    begin : result_receiver
        int unsigned hold_left;
        hold_left = 0;
        med_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                med_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (no_idling)
                med_ch.ready <= 1'b1;
            else
                med_ch.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run exceeded %0d cycles with %0d medians outstanding.",
                     CYCLE_LIMIT, expected_medians.size());
            $display("** median_of_3x3_window_core: FAILED **");
            $finish;
        end
    end

    // Offer one window, with a random gap first unless no_idling is set, and hold it until the transfer.
    task automatic send_window(input window_t px);
        if (!no_idling)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                win_ch.valid   <= 1'b0;
                win_ch.pixel_0 <= pixel_t'($urandom);
                win_ch.pixel_4 <= pixel_t'($urandom);
                win_ch.pixel_8 <= pixel_t'($urandom);
                @(posedge clk);
            end
        end
        win_ch.valid   <= 1'b1;
        win_ch.pixel_0 <= px[0];
        win_ch.pixel_1 <= px[1];
        win_ch.pixel_2 <= px[2];
        win_ch.pixel_3 <= px[3];
        win_ch.pixel_4 <= px[4];
        win_ch.pixel_5 <= px[5];
        win_ch.pixel_6 <= px[6];
        win_ch.pixel_7 <= px[7];
        win_ch.pixel_8 <= px[8];
        do
            @(posedge clk);
        while (win_ch.ready !== 1'b1);
    endtask

    // Stop offering and wait until every predicted median has been seen.
    task automatic wait_until_drained();
        win_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_medians.size() != 0);
    endtask

    task automatic make_random_window(input window_style_t style, output window_t w);
        pixel_t band_base;
        pixel_t backdrop;
        band_base = pixel_t'($urandom_range(0, 252));
        backdrop  = pixel_t'($urandom);
        for (int i = 0; i < WIN_PIXELS; i++)
        begin
            case (style)
                STYLE_UNIFORM:     w[i] = pixel_t'($urandom);
                STYLE_NARROW_BAND: w[i] = band_base + pixel_t'($urandom_range(0, 3));
                STYLE_SALT_PEPPER: w[i] = $urandom_range(0, 1) ? '1 : '0;
                STYLE_IMPULSE:     w[i] = ($urandom_range(0, 99) < 30) ?
                                          pixel_t'($urandom) : backdrop;
            endcase
        end
    endtask

    // Corner windows: extremes, ties at the median, lone outliers and bit patterns.
    task automatic test_directed_windows();
        window_t w;
        for (int k = 0; k < NUM_DIRECTED; k++)
        begin
            for (int i = 0; i < WIN_PIXELS; i++)
            begin
                case (k)
                    0:  w[i] = '0;
                    1:  w[i] = '1;
                    2:  w[i] = pixel_t'(i + 1);
                    3:  w[i] = pixel_t'(255 - i);
                    4:  w[i] = 8'h80;
                    // Majority at full scale, then majority at zero.
                    5:  w[i] = (i < 4) ? '0 : '1;
                    6:  w[i] = (i < 5) ? '0 : '1;
                    7:  w[i] = (i % 2 == 0) ? 8'hAA : 8'h55;
                    // A single outlier in the centre must be rejected.
                    8:  w[i] = (i == 4) ? '1 : 8'd10;
                    9:  w[i] = (i == 4) ? '0 : 8'd200;
                    // Repeated values straddling the middle position.
                    10: w[i] = (i < 3) ? 8'd3 : ((i < 7) ? 8'd5 : 8'd8);
                    11: w[i] = pixel_t'(1 << (i % 8));
                    12: w[i] = ~pixel_t'(1 << (i % 8));
                endcase
            end
            send_window(w);
        end
    endtask

    // Random windows of every content style with random idling on both sides.
    task automatic test_random_windows(input int unsigned count);
        window_t w;
        for (int unsigned n = 0; n < count; n++)
        begin
            make_random_window(window_style_t'($urandom_range(0, 3)), w);
            send_window(w);
        end
    endtask

    // A long stretch with a window offered and a result taken on every cycle.
    task automatic test_back_to_back(input int unsigned count);
        window_t w;
        no_idling = 1'b1;
        for (int unsigned n = 0; n < count; n++)
        begin
            make_random_window(window_style_t'($urandom_range(0, 3)), w);
            send_window(w);
        end
        no_idling = 1'b0;
    endtask

    // The receiver holds off while windows keep coming, so the pipeline fills and stalls.
    task automatic test_result_backpressure(input int unsigned count);
        window_t w;
        no_idling    = 1'b1;
        hold_request = 1'b1;
        for (int unsigned n = 0; n < count; n++)
        begin
            make_random_window(STYLE_UNIFORM, w);
            send_window(w);
        end
        no_idling = 1'b0;
    endtask

    // Bursts separated by pauses in which the pipeline empties completely.
    task automatic test_drain_between_bursts(input int unsigned bursts,
                                             input int unsigned count);
        for (int unsigned b = 0; b < bursts; b++)
        begin
            wait_until_drained();
            test_random_windows(count);
        end
    endtask

    task automatic finish_run();
        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_medians.size() != 0)
            note_failure($sformatf("%0d medians never arrived", expected_medians.size()));
        $display("Filtered %0d windows (%0d corner cases), %0d medians checked, %0d failures.",
                 windows_accepted, NUM_DIRECTED, medians_checked, failure_count);
        $display("Input was held back for %0d cycles by result back-pressure and stalls.",
                 input_stall_cycles);
        if (failure_count == 0)
            $display("** median_of_3x3_window_core: PASSED **");
        else
            $display("** median_of_3x3_window_core: FAILED **");
        $finish;
    endtask

    // Reset once, then run the tests in turn.
    initial
    begin
        rst_n          <= 1'b0;
        win_ch.valid   <= 1'b0;
        win_ch.pixel_0 <= '0;
        win_ch.pixel_1 <= '0;
        win_ch.pixel_2 <= '0;
        win_ch.pixel_3 <= '0;
        win_ch.pixel_4 <= '0;
        win_ch.pixel_5 <= '0;
        win_ch.pixel_6 <= '0;
        win_ch.pixel_7 <= '0;
        win_ch.pixel_8 <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_windows();
        test_random_windows(760);
        test_back_to_back(320);
        test_result_backpressure(48);
        test_drain_between_bursts(4, 50);
        finish_run();
    end

endmodule
